// ----- sv/utf8_line_word_counter_macros.svh -----
`ifndef UTF8_LINE_WORD_COUNTER_MACROS_SVH
`define UTF8_LINE_WORD_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ULWC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define ULWC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ulwc_pkg.sv -----
`default_nettype none

package ulwc_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int OUT_WIDTH = 32;

  // Input operations
  localparam logic [1:0] OP_DATA   = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  // Configuration register indexes
  localparam logic CFG_COUNT_WORDS = 1'b0;
  localparam logic CFG_COUNT_LINES = 1'b1;

  // Item classes handed from front to back
  localparam logic [2:0] K_IGN    = 3'd0;
  localparam logic [2:0] K_PRINT  = 3'd1;
  localparam logic [2:0] K_SEP    = 3'd2;
  localparam logic [2:0] K_NL     = 3'd3;
  localparam logic [2:0] K_BRK    = 3'd4;
  localparam logic [2:0] K_HIGH   = 3'd5;
  localparam logic [2:0] K_START  = 3'd6;
  localparam logic [2:0] K_FINISH = 3'd7;

  // Byte constants
  localparam logic [7:0] MASK_LEAD6 = 8'd252;
  localparam logic [7:0] MASK_LEAD5 = 8'd248;
  localparam logic [7:0] MASK_LEAD4 = 8'd240;
  localparam logic [7:0] MASK_LEAD3 = 8'd224;
  localparam logic [7:0] MASK_LEAD2 = 8'd192;
  localparam logic [7:0] ASCII_MAX  = 8'd127;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TILDE   = 8'h7E;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] lead;   // bytes to skip after a lead byte, zero for a continuation
    logic       cw;
    logic       cl;
  } item_t;

endpackage

`default_nettype wire

// ----- sv/ulwc_front.sv -----
`default_nettype none

module ulwc_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     op,
  input  wire logic [7:0]     data_byte,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic           cfg_index,
  input  wire logic           cfg_data,
  input  wire logic           q_full,
  output logic                q_push,
  output ulwc_pkg::item_t     q_item
);
  import ulwc_pkg::*;

  logic count_words;
  logic count_lines;
  logic [2:0] lead;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign q_push    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_words <= 1'b1;
      count_lines <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COUNT_WORDS: count_words <= cfg_data;
        CFG_COUNT_LINES: count_lines <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if ((data_byte & MASK_LEAD6) == MASK_LEAD6) lead = 3'd5;
    else if ((data_byte & MASK_LEAD5) == MASK_LEAD5) lead = 3'd4;
    else if ((data_byte & MASK_LEAD4) == MASK_LEAD4) lead = 3'd3;
    else if ((data_byte & MASK_LEAD3) == MASK_LEAD3) lead = 3'd2;
    else if ((data_byte & MASK_LEAD2) == MASK_LEAD2) lead = 3'd1;
    else lead = 3'd0;
  end

  always_comb begin
    q_item.lead = lead;
    q_item.cw   = count_words;
    q_item.cl   = count_lines;
    case (op)
      OP_DATA: begin
        if (!count_words && !count_lines) begin
          q_item.kind = K_IGN;
        end else if (data_byte > ASCII_MAX) begin
          q_item.kind = K_HIGH;
        end else if (count_lines && data_byte == CH_NL) begin
          q_item.kind = K_NL;
        end else if (count_lines && (data_byte == CH_CR || data_byte == CH_FF ||
                                     data_byte == CH_VT)) begin
          q_item.kind = K_BRK;
        end else if (count_words && (data_byte == CH_TAB || data_byte == CH_SPACE)) begin
          q_item.kind = K_SEP;
        end else if (data_byte >= CH_SPACE && data_byte <= CH_TILDE) begin
          q_item.kind = K_PRINT;
        end else begin
          q_item.kind = K_IGN;
        end
      end
      OP_START:  q_item.kind = K_START;
      OP_FINISH: q_item.kind = K_FINISH;
      default:   q_item.kind = K_IGN;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/ulwc_fifo.sv -----
`default_nettype none

module ulwc_fifo #(
  parameter int DEPTH = ulwc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire ulwc_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                pop_valid,
  output ulwc_pkg::item_t     pop_item
);
  import ulwc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] cnt;

  assign full      = (cnt == CW'(DEPTH));
  assign pop_valid = (cnt != '0);
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/ulwc_back.sv -----
`default_nettype none

`include "utf8_line_word_counter_macros.svh"

module ulwc_back #(
  parameter int COUNT_WIDTH = ulwc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire ulwc_pkg::item_t q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [31:0]         line_count,
  output logic [31:0]         word_count,
  output logic [31:0]         longest_line,
  output logic                final_res
);
  import ulwc_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic                   started, started_next;
  logic [2:0]             skip_left, skip_left_next;
  logic                   after_break, after_break_next;
  logic                   in_word, in_word_next;
  logic [COUNT_WIDTH-1:0] line_len, line_len_next;
  logic [COUNT_WIDTH-1:0] lines_seen, lines_seen_next;
  logic [COUNT_WIDTH-1:0] words_seen, words_seen_next;
  logic [COUNT_WIDTH-1:0] longest_seen, longest_seen_next;
  logic                   do_end;
  logic                   do_raise;
  logic                   fin;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [31:0] to_out(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH+31:0] ext;
    ext    = {{32{1'b0}}, v};
    to_out = ext[31:0];
  endfunction

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    started_next      = started;
    skip_left_next    = skip_left;
    after_break_next  = after_break;
    in_word_next      = in_word;
    line_len_next     = line_len;
    lines_seen_next   = lines_seen;
    words_seen_next   = words_seen;
    longest_seen_next = longest_seen;
    do_end            = 1'b0;
    do_raise          = 1'b0;
    fin               = 1'b0;
    case (q_item.kind)
      K_PRINT: begin
        if (started) begin
          line_len_next = sat_inc(line_len);
          in_word_next  = 1'b1;
        end
      end
      K_SEP: begin
        if (started) begin
          line_len_next = sat_inc(line_len);
          do_end        = 1'b1;
        end
      end
      K_NL: begin
        if (started) begin
          lines_seen_next  = sat_inc(lines_seen);
          do_raise         = !after_break;
          line_len_next    = '0;
          after_break_next = 1'b0;
          do_end           = 1'b1;
        end
      end
      K_BRK: begin
        if (started) begin
          do_end           = 1'b1;
          after_break_next = 1'b1;
          do_raise         = 1'b1;
        end
      end
      K_HIGH: begin
        if (started) begin
          if (skip_left != 3'd0) begin
            skip_left_next = skip_left - 1'b1;
          end else if (q_item.lead != 3'd0) begin
            // lead byte: one column, part of a word
            skip_left_next = q_item.lead;
            line_len_next  = sat_inc(line_len);
            in_word_next   = 1'b1;
          end
        end
      end
      K_START: begin
        if (!started) begin
          started_next = 1'b1;
          if (q_item.cl) begin
            lines_seen_next = sat_inc(lines_seen);
          end
        end
        skip_left_next   = 3'd0;
        after_break_next = 1'b0;
      end
      K_FINISH: begin
        fin      = 1'b1;
        do_end   = started;
        do_raise = started && q_item.cl;
      end
      default: ;
    endcase
    if (do_end && q_item.cw && in_word) begin
      in_word_next    = 1'b0;
      words_seen_next = sat_inc(words_seen);
    end
    if (do_raise && line_len > longest_seen) begin
      longest_seen_next = line_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started      <= 1'b0;
      skip_left    <= 3'd0;
      after_break  <= 1'b0;
      in_word      <= 1'b0;
      line_len     <= '0;
      lines_seen   <= '0;
      words_seen   <= '0;
      longest_seen <= '0;
    end else if (q_pop) begin
      if (fin) begin
        // report first, then drop all stream state
        started      <= 1'b0;
        skip_left    <= 3'd0;
        after_break  <= 1'b0;
        in_word      <= 1'b0;
        line_len     <= '0;
        lines_seen   <= '0;
        words_seen   <= '0;
        longest_seen <= '0;
      end else begin
        started      <= started_next;
        skip_left    <= skip_left_next;
        after_break  <= after_break_next;
        in_word      <= in_word_next;
        line_len     <= line_len_next;
        lines_seen   <= lines_seen_next;
        words_seen   <= words_seen_next;
        longest_seen <= longest_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      line_count   <= to_out(lines_seen_next);
      word_count   <= to_out(words_seen_next);
      longest_line <= to_out(longest_seen_next);
      final_res    <= fin;
    end
  end

  `ULWC_ASSERT_IMP(a_skip_range, 1'b1, skip_left <= 3'd5, "skip count out of range")
  `ULWC_ASSERT_IMP(a_idle_clear, !started,
                   skip_left == 3'd0 && !in_word && line_len == '0 && lines_seen == '0,
                   "state not clear outside a stream")
  `ULWC_ASSERT_NXT(a_finish_clears, q_pop && q_item.kind == K_FINISH,
                   !started && words_seen == '0 && longest_seen == '0 && final_res,
                   "finish did not clear state")
  `ULWC_ASSERT_NXT(a_break_raise, q_pop && q_item.kind == K_BRK && started,
                   longest_seen >= line_len && after_break,
                   "longest line not raised at a break")

endmodule

`default_nettype wire

// ----- sv/utf8_line_word_counter.sv -----
// UTF-8 line/word/longest-line counter. Text bytes arrive between a chunk-start
// and a finish transaction; every input transaction yields exactly one result
// carrying the running line, word and longest-line counts (COUNT_WIDTH-bit
// saturating counters, low 32 bits shown), with final_res set on the answer to
// a finish, after which all counts clear. The block takes one transaction per
// clock while the queue has room: the front classifies each byte against the
// two configuration bits and writes it into a QUEUE_DEPTH-entry queue, and the
// back pops one entry per cycle, unless the output is stalled, into the
// counters and the output register. A result is registered when its entry is
// popped from the queue. While the output is stalled the queue fills and
// in_ready drops. The combinational counter update (saturating adds and a
// longest-line compare) sets the pop rate. Write the configuration only while
// no transaction is in flight.
`default_nettype none

module utf8_line_word_counter #(
  parameter int COUNT_WIDTH = ulwc_pkg::COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = ulwc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      line_count,
  output logic [31:0]      word_count,
  output logic [31:0]      longest_line,
  output logic             final_res,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data
);
  import ulwc_pkg::*;

  item_t push_item;
  item_t pop_item;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;

  ulwc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .data_byte (data_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  ulwc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  ulwc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (pop_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .line_count   (line_count),
    .word_count   (word_count),
    .longest_line (longest_line),
    .final_res    (final_res)
  );

endmodule

`default_nettype wire
